// ===== rtl/core/hhlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types and constants for the header line parser: line states, byte
// classes, separator characters and field widths.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValW   = 13;
  localparam int unsigned LimW   = 12;
  localparam int unsigned ClassW = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [KeyW-1:0] KEY_MAX       = 16'hFFFF;
  localparam logic [LimW-1:0] MAX_LEN_RESET = 12'd255;

  typedef enum logic [0:0] {
    OP_PARSE   = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_END_LF = 4'd8
  } line_state_t;

  typedef enum logic [ClassW-1:0] {
    CL_SKIP  = 4'd0,
    CL_KEY   = 4'd1,
    CL_COLON = 4'd2,
    CL_SPACE = 4'd3,
    CL_VALUE = 4'd4,
    CL_CR    = 4'd5,
    CL_LF    = 4'd6,
    CL_FCR   = 4'd7,
    CL_FLF   = 4'd8,
    CL_AFTER = 4'd9,
    CL_ERR   = 4'd10
  } byte_class_t;

endpackage

// ===== rtl/core/hhlp_if.sv =====
// ----------------------------------------------------------------------------
// hhlp_if
// Valid/ready channels of the header line parser: byte requests, results
// and the limit register write port.
// ----------------------------------------------------------------------------
interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface hhlp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_class;
  logic [15:0] key_length;
  logic [12:0] value_length;
  logic        field_complete;
  logic        headers_done;
  logic        parse_error;

  modport source (output valid, output byte_class, output key_length,
                  output value_length, output field_complete,
                  output headers_done, output parse_error, input ready);
  modport sink   (input valid, input byte_class, input key_length,
                  input value_length, input field_complete,
                  input headers_done, input parse_error, output ready);
endinterface

interface hhlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/http_header_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// http_header_line_parser_core
// Byte-serial HTTP header block parser with field length reporting.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per header byte (operation 0) or a restart of the
//            block (operation 1). Accepted when valid and ready are high.
//   out_ch : one result per request: byte class, key/value lengths on the
//            LF closing a field, end-of-block flag and sticky error flag.
//   cfg_ch : writes the value length limit; always ready. Write only while
//            no request is in flight.
// A result follows its request in the next cycle; one request per cycle is
// sustained while results are taken, set by the single result register.
// in_ch.ready is high whenever the result register is empty or being taken
// this cycle, so a stalled receiver holds the result and back-pressures the
// sender after one request.
// Reset clears the line state, counters, error flag and result valid flag and
// loads the limit with 255.
// ----------------------------------------------------------------------------
module http_header_line_parser_core (
  input  logic             clk,
  input  logic             rst_n,
  hhlp_in_if.sink          in_ch,
  hhlp_out_if.source       out_ch,
  hhlp_cfg_if.sink         cfg_ch
);

  hhlp_pkg::line_state_t         state_r, state_nxt;
  logic [hhlp_pkg::KeyW-1:0]     key_count_r, key_count_nxt;
  logic [hhlp_pkg::ValW-1:0]     value_count_r, value_count_nxt;
  logic                          error_r, error_nxt;
  logic [hhlp_pkg::LimW-1:0]     max_len_r;

  logic                          out_valid_r;
  hhlp_pkg::byte_class_t         class_r, class_nxt;
  logic [hhlp_pkg::KeyW-1:0]     klen_r, klen_nxt;
  logic [hhlp_pkg::ValW-1:0]     vlen_r, vlen_nxt;
  logic                          fc_r, fc_nxt;
  logic                          done_r, done_nxt;
  logic                          perr_r;

  logic                          in_fire;
  logic                          bad;
  logic [7:0]                    b;
  logic                          is_cr, is_lf;

  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign b     = in_ch.data_byte;
  assign is_cr = (b == hhlp_pkg::CH_CR);
  assign is_lf = (b == hhlp_pkg::CH_LF);

  always_comb begin
    state_nxt       = state_r;
    key_count_nxt   = key_count_r;
    value_count_nxt = value_count_r;
    error_nxt       = error_r;
    class_nxt       = hhlp_pkg::CL_ERR;
    klen_nxt        = '0;
    vlen_nxt        = '0;
    fc_nxt          = 1'b0;
    done_nxt        = 1'b0;
    bad             = 1'b0;
    if (hhlp_pkg::op_t'(in_ch.operation) == hhlp_pkg::OP_RESTART) begin
      state_nxt       = hhlp_pkg::ST_START;
      key_count_nxt   = '0;
      value_count_nxt = '0;
      error_nxt       = 1'b0;
    end else if (!error_r) begin
      unique case (state_r)
        hhlp_pkg::ST_START: begin
          if (is_cr || is_lf) begin
            class_nxt = hhlp_pkg::CL_SKIP;
          end else begin
            state_nxt     = hhlp_pkg::ST_KEY;
            key_count_nxt = hhlp_pkg::KeyW'(1);
            class_nxt     = hhlp_pkg::CL_KEY;
          end
        end
        hhlp_pkg::ST_KEY: begin
          if (b == hhlp_pkg::CH_COLON) begin
            state_nxt = hhlp_pkg::ST_COLON;
            class_nxt = hhlp_pkg::CL_COLON;
          end else if (is_cr || is_lf) begin
            bad = 1'b1;
          end else begin
            if (key_count_r != hhlp_pkg::KEY_MAX) begin
              key_count_nxt = key_count_r + hhlp_pkg::KeyW'(1);
            end
            class_nxt = hhlp_pkg::CL_KEY;
          end
        end
        hhlp_pkg::ST_COLON: begin
          if (b == hhlp_pkg::CH_SPACE) begin
            state_nxt = hhlp_pkg::ST_SPACE;
            class_nxt = hhlp_pkg::CL_SPACE;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::ST_SPACE: begin
          state_nxt       = hhlp_pkg::ST_VALUE;
          value_count_nxt = hhlp_pkg::ValW'(1);
          class_nxt       = hhlp_pkg::CL_VALUE;
        end
        hhlp_pkg::ST_VALUE: begin
          if (is_cr) begin
            state_nxt = hhlp_pkg::ST_CR;
            class_nxt = hhlp_pkg::CL_CR;
          end else if (value_count_r > hhlp_pkg::ValW'(max_len_r)) begin
            bad = 1'b1;
          end else begin
            value_count_nxt = value_count_r + hhlp_pkg::ValW'(1);
            class_nxt       = hhlp_pkg::CL_VALUE;
          end
        end
        hhlp_pkg::ST_CR: begin
          if (is_lf) begin
            state_nxt = hhlp_pkg::ST_LF;
            class_nxt = hhlp_pkg::CL_LF;
            fc_nxt    = 1'b1;
            klen_nxt  = key_count_r;
            vlen_nxt  = value_count_r;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::ST_LF: begin
          if (is_cr) begin
            state_nxt = hhlp_pkg::ST_END_CR;
            class_nxt = hhlp_pkg::CL_FCR;
          end else begin
            state_nxt     = hhlp_pkg::ST_KEY;
            key_count_nxt = hhlp_pkg::KeyW'(1);
            class_nxt     = hhlp_pkg::CL_KEY;
          end
        end
        hhlp_pkg::ST_END_CR: begin
          if (is_lf) begin
            state_nxt = hhlp_pkg::ST_END_LF;
            class_nxt = hhlp_pkg::CL_FLF;
            done_nxt  = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::ST_END_LF: begin
          class_nxt = hhlp_pkg::CL_AFTER;
        end
        default: begin
          state_nxt = hhlp_pkg::ST_START;
          bad       = 1'b1;
        end
      endcase
      if (bad) begin
        error_nxt = 1'b1;
        class_nxt = hhlp_pkg::CL_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hhlp_pkg::ST_START;
      key_count_r   <= '0;
      value_count_r <= '0;
      error_r       <= 1'b0;
      max_len_r     <= hhlp_pkg::MAX_LEN_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.data;
      end
      if (in_fire) begin
        state_r       <= state_nxt;
        key_count_r   <= key_count_nxt;
        value_count_r <= value_count_nxt;
        error_r       <= error_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      class_r <= class_nxt;
      klen_r  <= klen_nxt;
      vlen_r  <= vlen_nxt;
      fc_r    <= fc_nxt;
      done_r  <= done_nxt;
      perr_r  <= error_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_class     = class_r;
  assign out_ch.key_length     = klen_r;
  assign out_ch.value_length   = vlen_r;
  assign out_ch.field_complete = fc_r;
  assign out_ch.headers_done   = done_r;
  assign out_ch.parse_error    = perr_r;

endmodule

// ===== rtl/core/hhlp_checker.sv =====
// ----------------------------------------------------------------------------
// hhlp_checker
// Port-level checks of the header line parser, bound to the core.
// ----------------------------------------------------------------------------
module hhlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  byte_class,
  input logic [15:0] key_length,
  input logic [12:0] value_length,
  input logic        field_complete,
  input logic        headers_done,
  input logic        parse_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_class)
      && $stable(key_length) && $stable(value_length))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_field_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_complete |->
      byte_class == hhlp_pkg::CL_LF && key_length != 16'd0
      && value_length != 13'd0 && !headers_done)
    else $error("bad field completion result");

  a_done_flf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && headers_done |-> byte_class == hhlp_pkg::CL_FLF && !parse_error)
    else $error("bad end of block result");

  a_err_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && parse_error |-> byte_class == hhlp_pkg::CL_ERR && !field_complete)
    else $error("error flag without error class");

endmodule

bind http_header_line_parser_core hhlp_checker u_hhlp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .byte_class     (out_ch.byte_class),
  .key_length     (out_ch.key_length),
  .value_length   (out_ch.value_length),
  .field_complete (out_ch.field_complete),
  .headers_done   (out_ch.headers_done),
  .parse_error    (out_ch.parse_error)
);
